// ----- design/udiv64_pkg.sv -----
// ----------------------------------------------------------------------------
// udiv64_pkg: shared definitions of the unsigned divider
// Field widths, the default data width and the link that joins neighboring
// cells of the divider row.
// ----------------------------------------------------------------------------
package udiv64_pkg;

    // Width of each dividend, divisor, quotient and remainder field on the ports.
    localparam int FIELD_W = 64;

    // Default number of bits that take part in the division.
    localparam int DEF_DATA_WIDTH = 64;

    // What one cell hands to the next, more significant, cell in each cycle.
    typedef struct packed {
        logic rem;     // partial remainder bit, shifted up by one place
        logic nq;      // dividend bit on its way out, quotient bit on its way in
        logic borrow;  // borrow of the trial subtraction
    } t_link;

endpackage

// ----- design/unsigned_divider_64_unit.sv -----
// ----------------------------------------------------------------------------
// unsigned_divider_64_unit: 64-bit unsigned restoring divider
// Returns the truncated quotient and the remainder of two unsigned operands,
// one quotient bit per cycle, on a row of identical bit-slice cells.
// ----------------------------------------------------------------------------
// The unit divides the low DATA_WIDTH bits of the dividend by the low
// DATA_WIDTH bits of the divisor and returns the exact quotient and remainder,
// zero-extended to 64 bits. A divisor that is zero in those bits sets the
// divide_by_zero flag in tuser, and quotient and remainder are then zero.
// The unit works on one item at a time. An item with a nonzero divisor steps
// through the cell row, one quotient bit per cycle from the most significant
// bit down, then moves to the output register through ST_DONE; a zero divisor
// skips the row and goes from ST_IDLE straight to ST_DONE. s_axis_tready comes
// back in the same cycle in which the result shows in the output register. That
// register holds a finished item while the next one is accepted and divided, so a
// slow consumer costs throughput only when a second result is ready before the
// first is taken.
// ----------------------------------------------------------------------------
module unsigned_divider_64_unit
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*FIELD_W-1:0] s_axis_tdata,   // dividend [63:0], divisor [127:64]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*FIELD_W-1:0] m_axis_tdata,   // quotient [63:0], remainder [127:64]
    output logic                 m_axis_tuser    // divide_by_zero
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

    // Controller states: idle and ready for an item, stepping through the
    // cell row, and waiting for the output register to be free.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_dz;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [FIELD_W-1:0] r_out_q;
    logic [FIELD_W-1:0] r_out_r;
    logic               r_out_dz;

    logic                  w_accept;
    logic                  w_step;
    logic                  w_take;
    logic                  w_out_load;
    logic                  w_zero_div;
    logic [DATA_WIDTH-1:0] w_dividend;
    logic [DATA_WIDTH-1:0] w_divisor;
    logic [DATA_WIDTH-1:0] w_q;
    logic [DATA_WIDTH-1:0] w_r;
    t_link                 w_in   [DATA_WIDTH];
    t_link                 w_out  [DATA_WIDTH];

    assign w_dividend = s_axis_tdata[DATA_WIDTH-1:0];
    assign w_divisor  = s_axis_tdata[FIELD_W +: DATA_WIDTH];
    assign w_zero_div = (w_divisor == '0);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_step        = (r_state == ST_RUN);
    assign w_out_load    = (r_state == ST_DONE) & (~r_out_valid | m_axis_tready);

    // The trial difference is kept when the shifted remainder overflowed its
    // width (the bit pushed out of the top cell) or when the subtraction left
    // no borrow. The same bit enters the row as the new quotient bit.
    assign w_take = w_out[DATA_WIDTH-1].rem | ~w_out[DATA_WIDTH-1].borrow;

    // Cell zero shifts in the dividend bit leaving the top cell, and starts
    // the borrow chain with no borrow.
    assign w_in[0].rem    = w_out[DATA_WIDTH-1].nq;
    assign w_in[0].nq     = w_take;
    assign w_in[0].borrow = 1'b0;

    for (genvar gi = 0; gi < DATA_WIDTH; gi++) begin : g_cell
        if (gi > 0) begin : g_link
            assign w_in[gi] = w_out[gi-1];
        end

        udiv64_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (w_accept),
            .i_step   (w_step),
            .i_take   (w_take),
            .i_load_n (w_dividend[gi]),
            .i_load_d (w_divisor[gi]),
            .i_prev   (w_in[gi]),
            .o_link   (w_out[gi])
        );

        // After the last step the shift register holds the quotient and the
        // remainder cells hold the remainder.
        assign w_q[gi] = w_out[gi].nq;
        assign w_r[gi] = w_out[gi].rem;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = w_zero_div ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dz <= w_zero_div;
        end
        if (w_out_load) begin
            r_out_q  <= r_dz ? '0 : FIELD_W'(w_q);
            r_out_r  <= r_dz ? '0 : FIELD_W'(w_r);
            r_out_dz <= r_dz;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_q};
    assign m_axis_tuser  = r_out_dz;

endmodule

// ----- design/udiv64_cell.sv -----
// ----------------------------------------------------------------------------
// udiv64_cell: one bit slice of the divider row
// Holds one bit of the partial remainder, of the divisor and of the combined
// dividend and quotient shift register, and one stage of the borrow chain.
// ----------------------------------------------------------------------------
module udiv64_cell
    import udiv64_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_load,    // start of an item: take the operand bits
    input  logic  i_step,    // one restoring division step
    input  logic  i_take,    // the trial difference replaces the remainder
    input  logic  i_load_n,  // dividend bit of this slice
    input  logic  i_load_d,  // divisor bit of this slice
    input  t_link i_prev,    // from the less significant neighbor
    output t_link o_link     // to the more significant neighbor
);

    logic r_rem;
    logic r_nq;
    logic r_d;
    logic n_rem;
    logic w_diff;

    // Bit of the trial subtraction of the divisor from the shifted remainder.
    assign w_diff = i_prev.rem ^ r_d ^ i_prev.borrow;
    assign n_rem  = i_take ? w_diff : i_prev.rem;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= 1'b0;
            r_nq  <= i_load_n;
            r_d   <= i_load_d;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_nq  <= i_prev.nq;
        end
    end

    assign o_link.rem    = r_rem;
    assign o_link.nq     = r_nq;
    assign o_link.borrow = (~i_prev.rem & r_d) | (~(i_prev.rem ^ r_d) & i_prev.borrow);

endmodule

// ----- design/udiv64_checker.sv -----
// ----------------------------------------------------------------------------
// udiv64_checker: port-level checks of the unsigned divider
// Watches the stream ports of the divider and flags latency, flag and
// handshake slips.
// ----------------------------------------------------------------------------
module udiv64_checker
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [2*FIELD_W-1:0] s_axis_tdata,   // dividend [63:0], divisor [127:64]
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [2*FIELD_W-1:0] m_axis_tdata,   // quotient [63:0], remainder [127:64]
    input logic                 m_axis_tuser    // divide_by_zero
);

    localparam int RUN_LAT = DATA_WIDTH + 2;

    logic w_in_acc;
    logic w_zero_div;

    assign w_in_acc   = s_axis_tvalid & s_axis_tready;
    assign w_zero_div = (s_axis_tdata[FIELD_W +: DATA_WIDTH] == '0);

    // A held result keeps its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    // A divide by zero result carries zero quotient and remainder.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("divide by zero result is not zero");

    // A zero divisor reaches a free output with the divide_by_zero flag set.
    a_dz_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_zero_div && !m_axis_tvalid |-> ##2 (m_axis_tvalid && m_axis_tuser))
        else $error("divide by zero result late or unflagged");

    // A nonzero divisor reaches a free output, unflagged, once every quotient bit is done.
    a_run_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !w_zero_div && !m_axis_tvalid |->
            ##RUN_LAT (m_axis_tvalid && !m_axis_tuser))
        else $error("division result late or flagged");

    // Input ready drops once an item is accepted, so no second item follows it directly.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

endmodule

bind unsigned_divider_64_unit udiv64_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_udiv64_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
